// ===== design/free_block_bitmap_allocator_defines.svh =====
// Assertion macros for the free-block bitmap allocator.
// Needs nothing else; the top level includes it for its checks.
`ifndef FREE_BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define FREE_BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FBBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fbba_pkg.sv =====
// Shared types and codes for the free-block bitmap allocator.
// Used by the front, the command queue, the back and the top level.
package fbba_pkg;

	localparam int BLOCK_COUNT_DEF = 64;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

	localparam int ACTION_W = 2;
	localparam int NEED_W   = 7;
	localparam int TARGET_W = 7;
	localparam int STATUS_W = 2;
	localparam int BLK_W    = 6;
	localparam int FREE_W   = 7;

	// Action codes of a request.
	localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOCK   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_UNLOCK = 2'd2;

	// Status codes of a result.
	localparam logic [STATUS_W-1:0] ST_VALID  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ACK    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [NEED_W-1:0]   needed_count;
		logic [TARGET_W-1:0] target_block;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BLK_W-1:0]    block_index;
		logic [FREE_W-1:0]   free_count;
		logic                last;
	} result_t;

	// Command classes handed from the front to the back.
	typedef enum logic [2:0] {
		CK_FIND,
		CK_SHORT,
		CK_ACK,
		CK_BADIDX,
		CK_LOCK,
		CK_UNLOCK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [NEED_W-1:0]   need;
		logic [TARGET_W-1:0] target;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

// ===== design/free_block_bitmap_allocator.sv =====
// Top level of the free-block bitmap allocator: front, command queue and back.
// Depends on fbba_pkg, fbba_front, fbba_queue, fbba_back and the defines header.
//
// The allocator keeps one occupied bit per block (all free after reset) and a
// count of free blocks. A request is taken at a clock edge where start is high
// and busy is low; busy is high only while the two-entry command queue is full.
// Results appear on result for exactly one cycle each, marked by done, and the
// receiver cannot hold them off. Lock, unlock, a zero-length find, an unused
// action and every error give a single result in the cycle after the back picks
// the command from the queue. A granted find of N blocks walks the occupancy
// map one block per cycle from block 0, gives one result for each free block
// it passes and stops at the N-th free block. That single map walk in the back
// sets the throughput; requests queued behind it wait their turn, and the front
// keeps taking requests until the queue fills. A find does not reserve the
// blocks it reports. The free count in each result is the count after the
// request's own effect.
`include "free_block_bitmap_allocator_defines.svh"

module free_block_bitmap_allocator #(
	parameter int BLOCK_COUNT = fbba_pkg::BLOCK_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  fbba_pkg::request_t request,
	output logic               done,
	output fbba_pkg::result_t  result
);

	logic              push;
	logic              pop;
	fbba_pkg::cmd_t    push_cmd;
	fbba_pkg::cmd_t    head_cmd;
	fbba_pkg::q_stat_t q_stat;

	assign busy = q_stat.full;

	fbba_front #(
		.BLOCK_COUNT(BLOCK_COUNT)
	) u_front (
		.start    (start),
		.request  (request),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	fbba_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.q_stat   (q_stat)
	);

	fbba_back #(
		.BLOCK_COUNT(BLOCK_COUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_cmd (head_cmd),
		.q_stat   (q_stat),
		.pop      (pop),
		.done     (done),
		.result   (result)
	);

	// A taken request must be sitting in the queue on the next cycle.
	`FBBA_ASSERT_NEXT(a_push_lands, clk, arst_n, start && !busy, !q_stat.empty, "request lost")

	// A reported free block lies inside the table.
	`FBBA_ASSERT_SAME(a_index_range, clk, arst_n, done && (result.status == fbba_pkg::ST_VALID), fbba_pkg::FREE_W'(result.block_index) < fbba_pkg::FREE_W'(BLOCK_COUNT), "block index out of range")

	// The free count never exceeds the table size.
	`FBBA_ASSERT_SAME(a_free_range, clk, arst_n, done, result.free_count <= fbba_pkg::FREE_W'(BLOCK_COUNT), "free count out of range")

endmodule

// ===== design/fbba_front.sv =====
// Front of the allocator: takes requests and sorts them into command classes.
// Depends on fbba_pkg.
module fbba_front #(
	parameter int BLOCK_COUNT = fbba_pkg::BLOCK_COUNT_DEF
) (
	input  logic              start,
	input  fbba_pkg::request_t request,
	input  fbba_pkg::q_stat_t q_stat,
	output logic              push,
	output fbba_pkg::cmd_t    push_cmd
);

	localparam logic [fbba_pkg::NEED_W-1:0]   NEED_MAX = fbba_pkg::NEED_W'(BLOCK_COUNT);
	localparam logic [fbba_pkg::TARGET_W-1:0] TGT_LIM  = fbba_pkg::TARGET_W'(BLOCK_COUNT);

	assign push = start && !q_stat.full;

	always_comb begin
		push_cmd.need   = request.needed_count;
		push_cmd.target = request.target_block;
		case (request.action)
			fbba_pkg::ACT_FIND: begin
				// Asking for more than the table holds can never be granted.
				if (request.needed_count == '0)
					push_cmd.kind = fbba_pkg::CK_ACK;
				else if (request.needed_count > NEED_MAX)
					push_cmd.kind = fbba_pkg::CK_SHORT;
				else
					push_cmd.kind = fbba_pkg::CK_FIND;
			end
			fbba_pkg::ACT_LOCK: begin
				if (request.target_block >= TGT_LIM)
					push_cmd.kind = fbba_pkg::CK_BADIDX;
				else
					push_cmd.kind = fbba_pkg::CK_LOCK;
			end
			fbba_pkg::ACT_UNLOCK: begin
				if (request.target_block >= TGT_LIM)
					push_cmd.kind = fbba_pkg::CK_BADIDX;
				else
					push_cmd.kind = fbba_pkg::CK_UNLOCK;
			end
			default: begin
				push_cmd.kind = fbba_pkg::CK_ACK;
			end
		endcase
	end

endmodule

// ===== design/fbba_queue.sv =====
// Short command queue between the front and the back of the allocator.
// Depends on fbba_pkg.
module fbba_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fbba_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output fbba_pkg::cmd_t    head_cmd,
	output fbba_pkg::q_stat_t q_stat
);

	localparam int QD = fbba_pkg::QUEUE_DEPTH;
	localparam int PW = fbba_pkg::QPTR_W;
	localparam int CW = fbba_pkg::QCNT_W;

	fbba_pkg::cmd_t   entry_q [QD];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		if (p == PW'(QD - 1))
			return '0;
		return p + PW'(1);
	endfunction

	assign head_cmd     = entry_q[rd_q];
	assign q_stat.empty = (cnt_q == '0);
	assign q_stat.full  = (cnt_q == CW'(QD));

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= next_ptr(wr_q);
			if (pop)
				rd_q <= next_ptr(rd_q);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ===== design/fbba_back.sv =====
// Back of the allocator: holds the occupancy map and free count, runs commands.
// Depends on fbba_pkg.
module fbba_back #(
	parameter int BLOCK_COUNT = fbba_pkg::BLOCK_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fbba_pkg::cmd_t    head_cmd,
	input  fbba_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              done,
	output fbba_pkg::result_t result
);

	localparam int IDX_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
	localparam int CNT_W = $clog2(BLOCK_COUNT + 1);

	typedef enum logic {
		B_IDLE,
		B_SCAN
	} bstate_t;

	bstate_t              state_q;
	logic [BLOCK_COUNT-1:0] occ_q;
	logic [CNT_W-1:0]     free_q;
	logic [IDX_W-1:0]     scan_q;
	logic [CNT_W-1:0]     found_q;
	logic [CNT_W-1:0]     need_q;
	logic                 done_q;
	fbba_pkg::result_t    result_q;

	logic [CNT_W-1:0] need_c;
	logic [IDX_W-1:0] tgt_c;
	logic             scan_last;

	// Front guarantees need is at most BLOCK_COUNT for finds and target in range for locks and unlocks here.
	assign need_c    = head_cmd.need[CNT_W-1:0];
	assign tgt_c     = head_cmd.target[IDX_W-1:0];
	assign scan_last = ((found_q + CNT_W'(1)) == need_q);
	assign pop       = (state_q == B_IDLE) && !q_stat.empty;
	assign done      = done_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			occ_q    <= '0;
			free_q   <= CNT_W'(BLOCK_COUNT);
			scan_q   <= '0;
			found_q  <= '0;
			need_q   <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!q_stat.empty) begin
						done_q                <= 1'b1;
						result_q.status       <= fbba_pkg::ST_ACK;
						result_q.block_index  <= '0;
						result_q.free_count   <= fbba_pkg::FREE_W'(free_q);
						result_q.last         <= 1'b1;
						case (head_cmd.kind)
							fbba_pkg::CK_FIND: begin
								if (need_c > free_q) begin
									result_q.status <= fbba_pkg::ST_SHORT;
								end else begin
									done_q  <= 1'b0;
									state_q <= B_SCAN;
									scan_q  <= '0;
									found_q <= '0;
									need_q  <= need_c;
								end
							end
							fbba_pkg::CK_SHORT: begin
								result_q.status <= fbba_pkg::ST_SHORT;
							end
							fbba_pkg::CK_BADIDX: begin
								result_q.status <= fbba_pkg::ST_BADIDX;
							end
							fbba_pkg::CK_LOCK: begin
								if (!occ_q[tgt_c]) begin
									occ_q[tgt_c]        <= 1'b1;
									free_q              <= free_q - CNT_W'(1);
									result_q.free_count <=
										fbba_pkg::FREE_W'(free_q - CNT_W'(1));
								end
							end
							fbba_pkg::CK_UNLOCK: begin
								if (occ_q[tgt_c]) begin
									occ_q[tgt_c]        <= 1'b0;
									free_q              <= free_q + CNT_W'(1);
									result_q.free_count <=
										fbba_pkg::FREE_W'(free_q + CNT_W'(1));
								end
							end
							default: begin
							end
						endcase
					end
				end
				B_SCAN: begin
					// One map bit per cycle; a free block yields one result.
					if (!occ_q[scan_q]) begin
						done_q               <= 1'b1;
						result_q.status      <= fbba_pkg::ST_VALID;
						result_q.block_index <= fbba_pkg::BLK_W'(scan_q);
						result_q.free_count  <= fbba_pkg::FREE_W'(free_q);
						result_q.last        <= scan_last;
						found_q              <= found_q + CNT_W'(1);
						if (scan_last)
							state_q <= B_IDLE;
					end
					scan_q <= scan_q + IDX_W'(1);
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule
